>>> rtl/ats_pkg.sv
// token scanner package: token kinds, scan modes, character codes and queue types
// no dependencies; imported by every module of the scanner
`default_nettype none

package ats_pkg;

	typedef enum logic [2:0] {
		K_IDENT   = 3'd0,
		K_DECIMAL = 3'd1,
		K_COMMA   = 3'd2,
		K_MINUS   = 3'd3,
		K_COLON   = 3'd4,
		K_NEWLINE = 3'd5,
		K_END     = 3'd6,
		K_ERROR   = 3'd7
	} kind_t;

	typedef enum logic [3:0] {
		M_IDLE   = 4'b0001,
		M_IDENT  = 4'b0010,
		M_NUMBER = 4'b0100,
		M_ERROR  = 4'b1000
	} mode_t;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_TAB   = 8'h09;

	localparam int Q_DEPTH    = 4;
	localparam int Q_PTR_BITS = 2;
	localparam int Q_CNT_BITS = 3;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] start;
		logic [15:0] len;
		logic [15:0] line;
		logic [7:0]  bad;
		logic        last;
	} tok_t;

	typedef struct packed {
		logic [1:0] n;
		tok_t       e0;
		tok_t       e1;
	} push_t;

endpackage

`default_nettype wire

>>> rtl/ats_front.sv
// scanner front: accepts source bytes, classifies them and keeps position, line and mode
// depends on ats_pkg; hands zero, one or two tokens per byte to the back queue
`default_nettype none

module ats_front import ats_pkg::*; #(
	parameter int POS_BITS = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       byte_valid,
	input  wire logic       room,
	input  wire logic [7:0] char_byte,
	input  wire logic       final_source,
	output push_t           push
);

	mode_t               mode_q, mode_d;
	logic [POS_BITS-1:0] start_q, start_d;
	logic [POS_BITS-1:0] pos_q, pos_d;
	logic [POS_BITS-1:0] line_q, line_d;
	logic [POS_BITS-1:0] pos_inc, line_inc;
	logic                accept, pend, v0, v1;
	logic                is_letter, is_num, is_skip;
	tok_t                r0, r1;

	function automatic logic [15:0] clamp16(input logic [POS_BITS-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
	endfunction

	assign accept    = byte_valid && room;
	assign pend      = (mode_q == M_IDENT) || (mode_q == M_NUMBER);
	assign pos_inc   = (pos_q != '1) ? pos_q + 1'b1 : pos_q;
	assign line_inc  = (line_q != '1) ? line_q + 1'b1 : line_q;
	assign is_num    = (char_byte >= CH_0) && (char_byte <= CH_9);
	assign is_letter = ((char_byte >= CH_LA) && (char_byte <= CH_LZ)) ||
		((char_byte >= CH_UA) && (char_byte <= CH_UZ)) || (char_byte == CH_UNDER);
	assign is_skip   = (char_byte == CH_SPACE) || (char_byte == CH_CR) ||
		(char_byte == CH_TAB);

	always_comb begin
		mode_d  = mode_q;
		start_d = start_q;
		pos_d   = pos_q;
		line_d  = line_q;
		v0      = 1'b0;
		v1      = 1'b0;
		r0.kind  = (mode_q == M_IDENT) ? K_IDENT : K_DECIMAL;
		r0.start = clamp16(start_q);
		r0.len   = clamp16(pos_q - start_q);
		r0.line  = clamp16(line_q);
		r0.bad   = 8'h00;
		r0.last  = 1'b0;
		r1.kind  = K_END;
		r1.start = clamp16(pos_q);
		r1.len   = 16'd1;
		r1.line  = clamp16(line_q);
		r1.bad   = 8'h00;
		r1.last  = 1'b1;
		if (char_byte == CH_NUL) begin
			v0      = pend;
			v1      = final_source;
			r1.len  = 16'd0;
			mode_d  = M_IDLE;
			start_d = '0;
			pos_d   = '0;
			line_d  = POS_BITS'(1);
		end else if (mode_q == M_ERROR) begin
			mode_d = M_ERROR;
		end else if ((mode_q == M_IDENT) && (is_letter || is_num)) begin
			pos_d = pos_inc;
		end else if ((mode_q == M_NUMBER) && is_num) begin
			pos_d = pos_inc;
		end else begin
			v0     = pend;
			mode_d = M_IDLE;
			if (is_skip) begin
				pos_d = pos_inc;
			end else if (is_letter) begin
				start_d = pos_q;
				pos_d   = pos_inc;
				mode_d  = M_IDENT;
			end else if (is_num) begin
				start_d = pos_q;
				pos_d   = pos_inc;
				mode_d  = M_NUMBER;
			end else if ((char_byte == CH_COMMA) || (char_byte == CH_MINUS) ||
					(char_byte == CH_COLON)) begin
				start_d = pos_q;
				pos_d   = pos_inc;
				v1      = 1'b1;
				r1.kind = (char_byte == CH_COMMA) ? K_COMMA :
					(char_byte == CH_MINUS) ? K_MINUS : K_COLON;
			end else if (char_byte == CH_LF) begin
				start_d = pos_q;
				pos_d   = pos_inc;
				line_d  = line_inc;
				v1      = 1'b1;
				r1.kind = K_NEWLINE;
				r1.line = clamp16(line_inc);
			end else begin
				start_d = pos_q;
				mode_d  = M_ERROR;
				v1      = 1'b1;
				r1.kind = K_ERROR;
				r1.bad  = char_byte;
			end
		end
	end

	// compact the two candidates so the first pushed entry is always e0
	always_comb begin
		push.n       = accept ? 2'({1'b0, v0} + {1'b0, v1}) : 2'd0;
		push.e0      = v0 ? r0 : r1;
		push.e0.last = !(v0 && v1);
		push.e1      = r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			start_q <= '0;
			pos_q   <= '0;
			line_q  <= POS_BITS'(1);
		end else if (accept) begin
			mode_q  <= mode_d;
			start_q <= start_d;
			pos_q   <= pos_d;
			line_q  <= line_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/ats_back.sv
// scanner back: token queue with two-entry push and an output register
// depends on ats_pkg; drives the token channel one beat per cycle while token_ready is high
`default_nettype none

module ats_back import ats_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire push_t  push,
	output logic        room,
	output logic        token_valid,
	input  wire logic   token_ready,
	output logic [2:0]  token_kind,
	output logic [15:0] start_offset,
	output logic [15:0] token_length,
	output logic [15:0] line_number,
	output logic [7:0]  bad_char,
	output logic        last_of_run
);

	tok_t                  mem_q [Q_DEPTH];
	logic [Q_PTR_BITS-1:0] wr_q, rd_q, wr1;
	logic [Q_CNT_BITS-1:0] cnt_q;
	logic                  pop, valid_q;
	tok_t                  out_q;

	assign room        = (cnt_q <= Q_CNT_BITS'(Q_DEPTH - 2));
	assign pop         = (cnt_q != '0) && (!valid_q || token_ready);
	assign wr1         = wr_q + 1'b1;
	assign token_valid = valid_q;
	assign token_kind   = out_q.kind;
	assign start_offset = out_q.start;
	assign token_length = out_q.len;
	assign line_number  = out_q.line;
	assign bad_char     = out_q.bad;
	assign last_of_run  = out_q.last;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_q] <= push.e0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr1] <= push.e1;
		end
		if (pop) begin
			out_q <= mem_q[rd_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			cnt_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			wr_q  <= wr_q + Q_PTR_BITS'(push.n);
			rd_q  <= rd_q + Q_PTR_BITS'(pop);
			cnt_q <= cnt_q + Q_CNT_BITS'(push.n) - Q_CNT_BITS'(pop);
			if (pop) begin
				valid_q <= 1'b1;
			end else if (token_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= Q_CNT_BITS'(Q_DEPTH))
		else $error("token queue count beyond depth");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n != 2'd0) |-> room)
		else $error("push into token queue without room");

	a_push_max: assert property (@(posedge clk) disable iff (!arst_n)
		push.n != 2'd3)
		else $error("more than two tokens pushed for one byte");

	a_pair_last: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n == 2'd2) |-> (!push.e0.last && push.e1.last))
		else $error("last flag misplaced in token pair");

endmodule

`default_nettype wire

>>> rtl/assembly_token_scanner_unit.sv
// assembly token scanner top level: byte channel in, token channel out
// depends on ats_pkg, ats_front and ats_back
//
// usage
//   byte channel: char_byte and final_source, handshake byte_valid / byte_ready.
//   a zero byte ends a source; final_source on it adds an end token.
//   token channel: token_kind, start_offset, token_length, line_number, bad_char,
//   last_of_run, handshake token_valid / token_ready.
//   each byte gives zero, one or two token beats; last_of_run marks the final one.
// timing
//   one byte accepted per cycle while the token queue has room for two entries.
//   a token is written into the queue when its byte is accepted and reaches the
//   token channel through the output register; the second token of a pair follows it.
//   sustained rate is one byte per cycle; token output is one beat per cycle,
//   so bytes that give two tokens slow the input when the queue fills.
// reset
//   arst_n clears mode, position (0), line (1), queue and output valid.
// stall
//   while token_ready is low the output holds and the queue (4 entries) fills;
//   byte_ready drops once fewer than two free entries remain.
`default_nettype none

module assembly_token_scanner_unit import ats_pkg::*; #(
	parameter int POS_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        byte_valid,
	output logic             byte_ready,
	input  wire logic [7:0]  char_byte,
	input  wire logic        final_source,
	output logic             token_valid,
	input  wire logic        token_ready,
	output logic [2:0]       token_kind,
	output logic [15:0]      start_offset,
	output logic [15:0]      token_length,
	output logic [15:0]      line_number,
	output logic [7:0]       bad_char,
	output logic             last_of_run
);

	push_t push;
	logic  room;

	assign byte_ready = room;

	ats_front #(
		.POS_BITS(POS_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.room        (room),
		.char_byte   (char_byte),
		.final_source(final_source),
		.push        (push)
	);

	ats_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.room        (room),
		.token_valid (token_valid),
		.token_ready (token_ready),
		.token_kind  (token_kind),
		.start_offset(start_offset),
		.token_length(token_length),
		.line_number (line_number),
		.bad_char    (bad_char),
		.last_of_run (last_of_run)
	);

endmodule

`default_nettype wire
